@@ sv/wstq_pkg.sv @@
package wstq_pkg;

  // Queue geometry
  localparam int WORKERS     = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int W_IDX   = $clog2(WORKERS);
  localparam int D_IDX   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS   = WORKERS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int TASK_W  = 16;
  localparam int WFIELD_W = 2;

  typedef enum logic {
    FN_PUSH  = 1'b0,
    FN_FETCH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_OWN    = 3'd0,
    ST_STOLEN = 3'd1,
    ST_SELF   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_PUSHED = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  // Decoded request waiting for the store read
  typedef struct packed {
    status_e               status;
    logic [WFIELD_W-1:0]   from_worker;
    logic                  rd;
  } wstq_res_t;

  // Store slot of entry at offset off from the head of queue q
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [W_IDX-1:0] q,
                                                  input logic [D_IDX-1:0] head,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0]    pos;
    logic [ADDR_W-1:0] base;
    pos = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (pos >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      pos = pos - (CNT_W+1)'(QUEUE_DEPTH);
    end
    base = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH);
    return ADDR_W'(base + ADDR_W'(pos));
  endfunction

endpackage

@@ sv/wstq_ram.sv @@
module wstq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/work_stealing_task_queues_core.sv @@
// Work-stealing task queues: one bounded double-ended queue of task ids per worker.
// Request channel: in_valid_i / in_stall_o with func_i, worker_i, victim_i, task_in_i.
//   A push appends task_in_i at the back of worker_i's queue (refused when full).
//   A fetch takes the front of worker_i's own queue, or else steals from the back
//   of queue victim_i; the victim is chosen by the requester.
// Result channel: out_valid_o / out_stall_i with status_o, task_out_o, from_worker_o.
//   Exactly one result per request, in request order. task_out_o and from_worker_o
//   are zero when no task is obtained.
// Pipeline: queue pointers update and the task store is accessed as a request is
//   accepted into the decode stage; the result register then loads from that stage.
// Throughput: one request per cycle while the result register is not held by
//   out_stall_i, set by the single port of the task store, which each request uses at most once.
// Stall: while the result register is held by out_stall_i, one more request can
//   sit in the decode stage; after that in_stall_o rises in the same cycle.
// Reset: all queues empty, both stages empty. The task store is not cleared; no
//   entry is read before it is written.
module work_stealing_task_queues_core
  import wstq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [WFIELD_W-1:0] worker_i,
  input  logic [WFIELD_W-1:0] victim_i,
  input  logic [TASK_W-1:0]   task_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [TASK_W-1:0]   task_out_o,
  output logic [WFIELD_W-1:0] from_worker_o
);

  logic [D_IDX-1:0] head_q [WORKERS];
  logic [D_IDX-1:0] head_d [WORKERS];
  logic [CNT_W-1:0] count_q [WORKERS];
  logic [CNT_W-1:0] count_d [WORKERS];

  logic             s1_valid_q;
  wstq_res_t        s1_res_q;
  wstq_res_t        res_d;

  logic                out_valid_q;
  status_e             status_q;
  logic [TASK_W-1:0]   task_q;
  logic [WFIELD_W-1:0] from_q;

  logic in_fire;
  logic out_load;

  logic [W_IDX-1:0]  wi;
  logic [W_IDX-1:0]  vi;
  logic              w_ok;
  logic              v_ok;
  logic [CNT_W-1:0]  own_cnt;
  logic [CNT_W-1:0]  vic_cnt;
  logic [D_IDX-1:0]  own_head;
  logic [D_IDX-1:0]  vic_head;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [TASK_W-1:0] mem_rdata;

  // Handshake: decode stage frees when the result register can load
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Queue selection
  assign wi       = W_IDX'(worker_i);
  assign vi       = W_IDX'(victim_i);
  assign w_ok     = 32'(worker_i) < 32'(WORKERS);
  assign v_ok     = 32'(victim_i) < 32'(WORKERS);
  assign own_cnt  = count_q[wi];
  assign vic_cnt  = count_q[vi];
  assign own_head = head_q[wi];
  assign vic_head = head_q[vi];

  // Request decode and pointer update
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    res_d    = '{status: ST_EMPTY, from_worker: '0, rd: 1'b0};
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;
    if (in_fire) begin
      if (func_e'(func_i) == FN_PUSH) begin
        if (!w_ok || own_cnt == CNT_W'(QUEUE_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.status = ST_PUSHED;
          mem_we       = 1'b1;
          mem_addr     = slot_addr(wi, own_head, own_cnt);
          count_d[wi]  = CNT_W'(own_cnt + 1'b1);
        end
      end else if (!w_ok) begin
        res_d.status = ST_EMPTY;
      end else if (own_cnt != '0) begin
        // own front
        res_d.status      = ST_OWN;
        res_d.from_worker = worker_i;
        res_d.rd          = 1'b1;
        mem_re            = 1'b1;
        mem_addr          = slot_addr(wi, own_head, '0);
        head_d[wi]        = (own_head == D_IDX'(QUEUE_DEPTH - 1)) ? '0
                                                                  : D_IDX'(own_head + 1'b1);
        count_d[wi]       = CNT_W'(own_cnt - 1'b1);
      end else if (victim_i == worker_i) begin
        res_d.status = ST_SELF;
      end else if (!v_ok || vic_cnt == '0) begin
        res_d.status = ST_EMPTY;
      end else begin
        // steal from the victim's back
        res_d.status      = ST_STOLEN;
        res_d.from_worker = victim_i;
        res_d.rd          = 1'b1;
        mem_re            = 1'b1;
        mem_addr          = slot_addr(vi, vic_head, CNT_W'(vic_cnt - 1'b1));
        count_d[vi]       = CNT_W'(vic_cnt - 1'b1);
      end
    end
  end

  wstq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (task_in_i),
    .rdata_o (mem_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORKERS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      s1_valid_q <= in_fire || (s1_valid_q && !out_load);
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q <= res_d;
    end
    if (out_load && s1_valid_q) begin
      status_q <= s1_res_q.status;
      task_q   <= s1_res_q.rd ? mem_rdata : '0;
      from_q   <= s1_res_q.from_worker;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign task_out_o    = task_q;
  assign from_worker_o = from_q;

`ifndef SYNTH
  logic cnt_over;

  always_comb begin
    cnt_over = 1'b0;
    for (int i = 0; i < WORKERS; i++) begin
      cnt_over = cnt_over | (count_q[i] > CNT_W'(QUEUE_DEPTH));
    end
  end

  // No queue ever holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) !cnt_over)
    else $error("queue count above depth");

  // Requests are only held off while the decode stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("request stalled with empty decode stage");

  // An accepted request always lands in the decode stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request lost");

  // No task obtained means a zero task id
  a_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OWN && status_o != ST_STOLEN) |-> task_out_o == '0)
    else $error("task id on a no-task result");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wstq_pkg::*;

  localparam int RAND_REQS     = 1225;
  localparam int DIRECTED_REQS = 25;
  localparam int TOTAL_REQS    = DIRECTED_REQS + RAND_REQS;
  localparam int QUIET_LIMIT   = 2000;
  localparam int CALM_TAIL     = 150;
  localparam int TAIL_CYCLES   = 10;

  typedef struct packed {
    func_e               fn;
    logic [WFIELD_W-1:0] wk;
    logic [WFIELD_W-1:0] vc;
    logic [TASK_W-1:0]   tid;
  } sched_req_t;

  typedef struct packed {
    status_e             st;
    logic [TASK_W-1:0]   tid;
    logic [WFIELD_W-1:0] src;
  } sched_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                func_i;
  logic [WFIELD_W-1:0] worker_i;
  logic [WFIELD_W-1:0] victim_i;
  logic [TASK_W-1:0]   task_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          status_o;
  logic [TASK_W-1:0]   task_out_o;
  logic [WFIELD_W-1:0] from_worker_o;

  // Requests waiting for the driver, and results owed by the block
  sched_req_t request_fifo [TOTAL_REQS];
  sched_res_t due_results  [TOTAL_REQS];
  int         req_wr;
  int         req_rd;
  int         due_wr;
  int         due_rd;

  // Shadow of the queues
  logic [TASK_W-1:0] shadow_store [SLOTS];
  int                shadow_head  [WORKERS];
  int                shadow_count [WORKERS];

  int  err_cnt;
  int  total_reqs;
  int  accepted_reqs;
  int  quiet_cycles;
  int  cyc_cnt;
  int  gap_pct;
  int  stall_pct;
  int  gap_left;
  int  stall_left;
  bit  req_taken;
  bit  res_taken;
  sched_req_t next_req;
  sched_req_t drv_req;
  sched_res_t want;
  sched_res_t got;

  work_stealing_task_queues_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .worker_i      (worker_i),
    .victim_i      (victim_i),
    .task_in_i     (task_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .task_out_o    (task_out_o),
    .from_worker_o (from_worker_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  function automatic sched_req_t mk_req(func_e fn, int wk, int vc, int tid);
    sched_req_t r;
    r.fn  = fn;
    r.wk  = WFIELD_W'(wk);
    r.vc  = WFIELD_W'(vc);
    r.tid = TASK_W'(tid);
    return r;
  endfunction

  // Append one request to the pending list
  task automatic add_req(input sched_req_t r);
    if (req_wr < TOTAL_REQS) begin
      request_fifo[req_wr] = r;
      req_wr++;
    end
  endtask

  // Idle probability for one phase of the run, in percent
  function automatic int pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 45;
    endcase
  endfunction

  // Work out what the block answers to one request and move the shadow queues
  task automatic serve_request(input sched_req_t rq, output sched_res_t rs);
    int w;
    int v;
    int slot;
    w = int'(rq.wk);
    v = int'(rq.vc);
    rs.st  = ST_EMPTY;
    rs.tid = '0;
    rs.src = '0;
    if (rq.fn == FN_PUSH) begin
      if (w >= WORKERS || shadow_count[w] >= QUEUE_DEPTH) begin
        rs.st = ST_FULL;
      end else begin
        slot = w * QUEUE_DEPTH + (shadow_head[w] + shadow_count[w]) % QUEUE_DEPTH;
        shadow_store[slot] = rq.tid;
        shadow_count[w]++;
        rs.st = ST_PUSHED;
      end
    end else if (w >= WORKERS) begin
      rs.st = ST_EMPTY;
    end else if (shadow_count[w] != 0) begin
      // own front
      slot = w * QUEUE_DEPTH + shadow_head[w];
      rs.st  = ST_OWN;
      rs.tid = shadow_store[slot];
      rs.src = rq.wk;
      shadow_head[w] = (shadow_head[w] + 1) % QUEUE_DEPTH;
      shadow_count[w]--;
    end else if (v == w) begin
      rs.st = ST_SELF;
    end else if (v >= WORKERS || shadow_count[v] == 0) begin
      rs.st = ST_EMPTY;
    end else begin
      // steal from the victim's back
      slot = v * QUEUE_DEPTH + (shadow_head[v] + shadow_count[v] - 1) % QUEUE_DEPTH;
      rs.st  = ST_STOLEN;
      rs.tid = shadow_store[slot];
      rs.src = rq.vc;
      shadow_count[v]--;
    end
  endtask

  // Sample both handshakes, check results, predict, watchdog
  always @(posedge clk_i) begin
    req_taken = rst_ni && in_valid_i && !in_stall_o;
    res_taken = rst_ni && out_valid_o && !out_stall_i;

    if (res_taken) begin
      if (due_rd == due_wr) begin
        err_cnt++;
        $display("%0t: unexpected result: status %0d task %h from %0d", $realtime,
                 status_o, task_out_o, from_worker_o);
      end else begin
        want = due_results[due_rd];
        due_rd++;
        if (status_o !== want.st) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.st, status_o);
        end
        if (task_out_o !== want.tid) begin
          err_cnt++;
          $display("%0t: task_out expected %h actual %h", $realtime, want.tid, task_out_o);
        end
        if (from_worker_o !== want.src) begin
          err_cnt++;
          $display("%0t: from_worker expected %0d actual %0d", $realtime, want.src,
                   from_worker_o);
        end
      end
    end

    if (req_taken) begin
      next_req.fn  = func_e'(func_i);
      next_req.wk  = worker_i;
      next_req.vc  = victim_i;
      next_req.tid = task_in_i;
      serve_request(next_req, got);
      due_results[due_wr] = got;
      due_wr++;
      accepted_reqs++;
    end

    // new idle mix at the start of each phase
    if (cyc_cnt % 200 == 0) begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
    end
    cyc_cnt++;

    if (req_taken || res_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request driver and result back-pressure, both on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if ((req_wr - req_rd) >= CALM_TAIL && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(7);
          in_valid_i <= 1'b0;
        end else if (req_wr != req_rd) begin
          drv_req = request_fifo[req_rd];
          req_rd++;
          in_valid_i <= 1'b1;
          func_i     <= drv_req.fn;
          worker_i   <= drv_req.wk;
          victim_i   <= drv_req.vc;
          task_in_i  <= drv_req.tid;
        end else begin
          in_valid_i <= 1'b0;
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ((req_wr - req_rd) >= CALM_TAIL && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int push_pct;
    int hot;
    sched_req_t rq;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_stall_i   = 1'b0;
    func_i        = FN_PUSH;
    worker_i      = '0;
    victim_i      = '0;
    task_in_i     = '0;
    err_cnt       = 0;
    accepted_reqs = 0;
    quiet_cycles  = 0;
    cyc_cnt       = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    gap_left      = 0;
    stall_left    = 0;
    req_taken     = 1'b0;
    res_taken     = 1'b0;
    req_wr        = 0;
    req_rd        = 0;
    due_wr        = 0;
    due_rd        = 0;
    for (int i = 0; i < WORKERS; i++) begin
      shadow_head[i]  = 0;
      shadow_count[i] = 0;
    end

    // directed: empty cases, own front, steal, fill one queue to refusal
    add_req(mk_req(FN_FETCH, 0, 0, 16'h1234));
    add_req(mk_req(FN_FETCH, 1, 2, 16'hFFFF));
    add_req(mk_req(FN_PUSH, 0, 3, 16'hFFFF));
    add_req(mk_req(FN_PUSH, 0, 0, 16'h0000));
    add_req(mk_req(FN_FETCH, 1, 0, 16'h0000));
    add_req(mk_req(FN_FETCH, 0, 3, 16'hFFFF));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      add_req(mk_req(FN_PUSH, 3, i % 4, (i % 2) ? 16'h5A5A ^ i : 16'hA5A5 ^ i));
    end
    add_req(mk_req(FN_PUSH, 3, 1, 16'hBEEF));
    add_req(mk_req(FN_FETCH, 2, 3, 16'h0000));
    add_req(mk_req(FN_FETCH, 3, 1, 16'hFFFF));

    // random: phases lean towards filling or draining, around one busy worker
    push_pct = 50;
    hot      = 0;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 80;
          default: push_pct = 95;
        endcase
        hot = $urandom_range(WORKERS - 1);
      end
      rq.fn  = ($urandom_range(99) < push_pct) ? FN_PUSH : FN_FETCH;
      rq.wk  = $urandom_range(1) ? WFIELD_W'(hot) : WFIELD_W'($urandom_range(3));
      rq.vc  = WFIELD_W'($urandom_range(3));
      rq.tid = TASK_W'($urandom_range(16'hFFFF));
      add_req(rq);
    end
    total_reqs = req_wr;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_reqs == total_reqs);
    while (due_rd != due_wr) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wstq_pkg.sv
sv/wstq_ram.sv
sv/work_stealing_task_queues_core.sv
tb/sv/testbench.sv
